>>> src/srs_pkg.sv
// ---------------------------------------------------------------------------
// srs_pkg
// Shared types, codes and field widths of the scroll roll sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

  // fixed field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned CANVAS_W  = 14;
  localparam int unsigned SPEED_W   = 11;
  localparam int unsigned DELAY_W   = 26;
  localparam int unsigned OFFSET_W  = 33;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned PROD_W    = SPEED_W + DT_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = DELAY_W;

  // register reset values
  localparam logic [CANVAS_W-1:0] CANVAS_RST = CANVAS_W'(1080);
  localparam logic [SPEED_W-1:0]  SPEED_RST  = SPEED_W'(60);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_ARM    = 3'd1,
    OP_RESET  = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_TOGGLE = 3'd5,
    OP_START  = 3'd6
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS      = 3'd0,
    CFG_STRIP       = 3'd1,
    CFG_SPEED       = 3'd2,
    CFG_LEAD_DELAY  = 3'd3,
    CFG_LOOP_EN     = 3'd4,
    CFG_ACTION_EN   = 3'd5,
    CFG_ACTION_DLY  = 3'd6
  } cfg_idx_t;

  // roll phase, one-hot internally
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_DELAY = 4'b0010,
    PH_ROLL  = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // phase codes as seen on the result channel
  localparam logic [PHASE_W-1:0] PHASE_IDLE_CODE  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_DELAY_CODE = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_ROLL_CODE  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_DONE_CODE  = 2'd3;

  // one result item
  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [OFFSET_W-1:0] offset;
    logic                fin;
    logic                fire;
    logic                paused;
  } srs_result_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE:  code = PHASE_IDLE_CODE;
      PH_DELAY: code = PHASE_DELAY_CODE;
      PH_ROLL:  code = PHASE_ROLL_CODE;
      PH_DONE:  code = PHASE_DONE_CODE;
      default:  code = PHASE_IDLE_CODE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> src/srs_step.sv
// ---------------------------------------------------------------------------
// srs_step
// Roll state registers and the next-state logic for one transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srs_step import srs_pkg::*; #(
  parameter int unsigned TIME_FRAC_BITS    = 16,
  parameter int unsigned STRIP_HEIGHT_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step_en,
  input  wire op_t                          op,
  input  wire logic [DT_W-1:0]              dt,
  input  wire logic [PROD_W-1:0]            prod,
  input  wire logic [CANVAS_W-1:0]          canvas_height,
  input  wire logic [STRIP_HEIGHT_BITS-1:0] strip_height,
  input  wire logic [DELAY_W-1:0]           lead_delay,
  input  wire logic                         loop_enable,
  input  wire logic                         action_enable,
  input  wire logic [DELAY_W-1:0]           action_delay,
  output srs_result_t                       res
);

  localparam int unsigned HGT_W    = (STRIP_HEIGHT_BITS > CANVAS_W) ?
                                     STRIP_HEIGHT_BITS : CANVAS_W;
  localparam int unsigned TRAVEL_W = HGT_W + 1 + TIME_FRAC_BITS;
  localparam int unsigned CMP_W    = (TRAVEL_W > OFFSET_W + 1) ? TRAVEL_W : OFFSET_W + 1;

  phase_t              phase_r, phase_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [DELAY_W-1:0]  delay_left_r, delay_left_nxt;
  logic [DELAY_W-1:0]  action_left_r, action_left_nxt;
  logic                action_wait_r, action_wait_nxt;
  logic                pause_r, pause_nxt;

  logic [CANVAS_W-1:0] canvas_eff;
  logic [HGT_W:0]      height_sum;
  logic [CMP_W-1:0]    travel;
  logic [CMP_W-1:0]    sum;
  logic [CMP_W-1:0]    wrapped;
  logic [DELAY_W-1:0]  dt_ext;
  logic                fin;
  logic                fire;

  // travel distance: canvas plus strip, a zero canvas counts as one
  assign canvas_eff = (canvas_height == '0) ? CANVAS_W'(1) : canvas_height;
  assign height_sum = (HGT_W + 1)'(canvas_eff) + (HGT_W + 1)'(strip_height);
  assign travel     = CMP_W'(height_sum) << TIME_FRAC_BITS;
  assign sum        = CMP_W'(offset_r) + CMP_W'(prod);
  assign wrapped    = sum - travel;
  assign dt_ext     = DELAY_W'(dt);

  // next state
  always_comb begin
    phase_nxt       = phase_r;
    offset_nxt      = offset_r;
    delay_left_nxt  = delay_left_r;
    action_left_nxt = action_left_r;
    action_wait_nxt = action_wait_r;
    pause_nxt       = pause_r;
    fin             = 1'b0;
    fire            = 1'b0;
    unique case (op)
      OP_TICK: begin
        if (phase_r == PH_DELAY) begin
          if (dt_ext >= delay_left_r) begin
            delay_left_nxt = '0;
            phase_nxt      = PH_ROLL;
          end else begin
            delay_left_nxt = delay_left_r - dt_ext;
          end
        end else if (phase_r == PH_ROLL && !pause_r) begin
          if (sum < travel) begin
            offset_nxt = sum[OFFSET_W-1:0];
          end else if (loop_enable) begin
            offset_nxt = wrapped[OFFSET_W-1:0];
          end else begin
            offset_nxt = travel[OFFSET_W-1:0];
            phase_nxt  = PH_DONE;
            fin        = 1'b1;
            if (action_enable) begin
              action_wait_nxt = 1'b1;
              action_left_nxt = action_delay;
            end
          end
        end
        // ending action countdown
        if (action_wait_r && !fin) begin
          if (dt_ext >= action_left_r) begin
            action_wait_nxt = 1'b0;
            action_left_nxt = '0;
            fire            = 1'b1;
          end else begin
            action_left_nxt = action_left_r - dt_ext;
          end
        end
        // zero action delay fires on the finishing tick
        if (fin && action_enable && action_delay == '0) begin
          action_wait_nxt = 1'b0;
          fire            = 1'b1;
        end
      end
      OP_ARM: begin
        phase_nxt       = (lead_delay != '0) ? PH_DELAY : PH_ROLL;
        offset_nxt      = '0;
        delay_left_nxt  = lead_delay;
        action_left_nxt = '0;
        action_wait_nxt = 1'b0;
        pause_nxt       = 1'b0;
      end
      OP_RESET: begin
        phase_nxt       = PH_IDLE;
        offset_nxt      = '0;
        delay_left_nxt  = '0;
        action_left_nxt = '0;
        action_wait_nxt = 1'b0;
        pause_nxt       = 1'b0;
      end
      OP_PAUSE:  pause_nxt = 1'b1;
      OP_RESUME: pause_nxt = 1'b0;
      OP_TOGGLE: pause_nxt = ~pause_r;
      OP_START: begin
        if (phase_r == PH_IDLE || phase_r == PH_DONE) begin
          phase_nxt       = (lead_delay != '0) ? PH_DELAY : PH_ROLL;
          offset_nxt      = '0;
          delay_left_nxt  = lead_delay;
          action_left_nxt = '0;
          action_wait_nxt = 1'b0;
          pause_nxt       = 1'b0;
        end else begin
          pause_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      offset_r      <= '0;
      delay_left_r  <= '0;
      action_left_r <= '0;
      action_wait_r <= 1'b0;
      pause_r       <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      offset_r      <= offset_nxt;
      delay_left_r  <= delay_left_nxt;
      action_left_r <= action_left_nxt;
      action_wait_r <= action_wait_nxt;
      pause_r       <= pause_nxt;
    end
  end

  // result of this transfer
  assign res.phase  = phase_code(phase_nxt);
  assign res.offset = offset_nxt;
  assign res.fin    = fin;
  assign res.fire   = fire;
  assign res.paused = pause_nxt;

endmodule

`default_nettype wire

>>> src/scroll_roll_sequencer_top.sv
// A transfer is taken into the input register, and its result is registered in the result register.
// Throughput: one item per cycle while out_stall is low; the input register holds the speed product and
// the step logic retires one item per cycle into the result register.
// in_stall follows out_stall only when both registers are full.
// Reset (rst_n low, synchronous): roll idle, offset zero, config back to defaults.
// ---------------------------------------------------------------------------
// scroll_roll_sequencer_top
// Scroll roll sequencer: input register, step logic, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scroll_roll_sequencer_top import srs_pkg::*; #(
  parameter int unsigned TIME_FRAC_BITS    = 16,
  parameter int unsigned STRIP_HEIGHT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [OP_W-1:0]       in_operation,
  input  wire logic [DT_W-1:0]       in_elapsed_time,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PHASE_W-1:0]         out_phase_now,
  output logic [OFFSET_W-1:0]        out_scroll_offset,
  output logic                       out_finished_pulse,
  output logic                       out_action_fire,
  output logic                       out_paused_now
);

  logic [CANVAS_W-1:0]          canvas_r;
  logic [STRIP_HEIGHT_BITS-1:0] strip_r;
  logic [SPEED_W-1:0]           speed_r;
  logic [DELAY_W-1:0]           lead_delay_r;
  logic                         loop_en_r;
  logic                         action_en_r;
  logic [DELAY_W-1:0]           action_delay_r;

  logic              s1_v_r;
  op_t               s1_op_r;
  logic [DT_W-1:0]   s1_dt_r;
  logic [PROD_W-1:0] s1_prod_r;

  logic        out_v_r;
  srs_result_t out_r;
  srs_result_t res;

  logic in_xfer;
  logic out_free;
  logic adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_r       <= CANVAS_RST;
      strip_r        <= '0;
      speed_r        <= SPEED_RST;
      lead_delay_r   <= '0;
      loop_en_r      <= 1'b0;
      action_en_r    <= 1'b0;
      action_delay_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CANVAS:      canvas_r       <= cfg_wdata[CANVAS_W-1:0];
        CFG_STRIP:       strip_r        <= cfg_wdata[STRIP_HEIGHT_BITS-1:0];
        CFG_SPEED:       speed_r        <= cfg_wdata[SPEED_W-1:0];
        CFG_LEAD_DELAY:  lead_delay_r   <= cfg_wdata[DELAY_W-1:0];
        CFG_LOOP_EN:     loop_en_r      <= cfg_wdata[0];
        CFG_ACTION_EN:   action_en_r    <= cfg_wdata[0];
        CFG_ACTION_DLY:  action_delay_r <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free = !out_v_r || !out_stall;
  assign adv      = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // input register, speed product taken here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= op_t'(in_operation);
      s1_dt_r   <= in_elapsed_time;
      s1_prod_r <= PROD_W'(speed_r) * PROD_W'(in_elapsed_time);
    end
  end

  srs_step #(
    .TIME_FRAC_BITS    (TIME_FRAC_BITS),
    .STRIP_HEIGHT_BITS (STRIP_HEIGHT_BITS)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (adv),
    .op            (s1_op_r),
    .dt            (s1_dt_r),
    .prod          (s1_prod_r),
    .canvas_height (canvas_r),
    .strip_height  (strip_r),
    .lead_delay    (lead_delay_r),
    .loop_enable   (loop_en_r),
    .action_enable (action_en_r),
    .action_delay  (action_delay_r),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_phase_now      = out_r.phase;
  assign out_scroll_offset  = out_r.offset;
  assign out_finished_pulse = out_r.fin;
  assign out_action_fire    = out_r.fire;
  assign out_paused_now     = out_r.paused;

endmodule

`default_nettype wire

>>> src/srs_checker.sv
// ---------------------------------------------------------------------------
// srs_checker
// Port-level checks of the scroll roll sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srs_checker import srs_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [PHASE_W-1:0]  out_phase_now,
  input wire logic [OFFSET_W-1:0] out_scroll_offset,
  input wire logic                out_finished_pulse,
  input wire logic                out_action_fire,
  input wire logic                out_paused_now
);

  // both sides empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("pipeline not empty after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scroll_offset)
      && $stable(out_phase_now) && $stable(out_finished_pulse)
      && $stable(out_action_fire) && $stable(out_paused_now))
    else $error("stalled result changed");

  // a finishing tick lands in the finished phase and was not paused
  a_fin_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished_pulse |-> out_phase_now == PHASE_DONE_CODE && !out_paused_now)
    else $error("finish pulse outside finished phase");

  // offset stays zero until rolling starts
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase_now == PHASE_IDLE_CODE || out_phase_now == PHASE_DELAY_CODE)
      |-> out_scroll_offset == '0)
    else $error("offset moved before rolling");

endmodule

bind scroll_roll_sequencer_top srs_checker u_srs_checker (.*);

`default_nettype wire

>>> test/scroll_roll_sequencer_top_tb.sv
// ---------------------------------------------------------------------------
// scroll_roll_sequencer_top_tb
// Self-checking bench for the scroll roll sequencer. A short table of directed
// transfers (reset state, pause handling, delay, finish, ending action, loop
// overshoot) is followed by random phases. Each phase writes a fresh register
// setting and then sends arm/start followed mostly by ticks. Every result is
// compared field by field against its typed value or an in-bench model of the
// roll, with random idle and stall bursts on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scroll_roll_sequencer_top_tb;
  import srs_pkg::*;

  localparam int unsigned TIME_FRAC     = 16;
  localparam int unsigned STRIP_W       = 16;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned QUIET_PHASES  = 2;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  // codes outside the defined lists
  localparam logic [OP_W-1:0]      OP_UNUSED  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // one line of the directed table: a register write or a transfer
  typedef struct packed {
    logic                  is_write;
    logic [2:0]            code;
    logic [CFG_DATA_W-1:0] arg;
    logic                  typed;
    srs_result_t           want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation = '0;
  logic [DT_W-1:0]       in_elapsed_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PHASE_W-1:0]    out_phase_now;
  logic [OFFSET_W-1:0]   out_scroll_offset;
  logic                  out_finished_pulse;
  logic                  out_action_fire;
  logic                  out_paused_now;

  // register copy
  logic [CANVAS_W-1:0]   cfg_canvas;
  logic [STRIP_W-1:0]    cfg_strip;
  logic [SPEED_W-1:0]    cfg_speed;
  logic [DELAY_W-1:0]    cfg_lead_delay;
  logic                  cfg_loop;
  logic                  cfg_action;
  logic [DELAY_W-1:0]    cfg_action_delay;

  // roll state copy
  logic [PHASE_W-1:0]    roll_phase;
  logic [OFFSET_W-1:0]   roll_offset;
  logic [DELAY_W-1:0]    delay_left;
  logic [DELAY_W-1:0]    action_left;
  logic                  action_pending;
  logic                  roll_paused;

  srs_result_t           expected_rolls[$];
  plan_row_t             directed_plan[$];

  int unsigned idle_pct = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned item_count = 0;
  int unsigned typed_count = 0;
  int unsigned result_count = 0;
  int unsigned finish_count = 0;
  int unsigned fire_count = 0;
  int unsigned write_count = 0;
  int unsigned mismatch_count = 0;

  scroll_roll_sequencer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_elapsed_time    (in_elapsed_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_phase_now      (out_phase_now),
    .out_scroll_offset  (out_scroll_offset),
    .out_finished_pulse (out_finished_pulse),
    .out_action_fire    (out_action_fire),
    .out_paused_now     (out_paused_now)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // roll state helpers
  function automatic void clear_roll();
    roll_phase     = PHASE_IDLE_CODE;
    roll_offset    = '0;
    delay_left     = '0;
    action_left    = '0;
    action_pending = 1'b0;
    roll_paused    = 1'b0;
  endfunction

  function automatic void arm_roll();
    clear_roll();
    delay_left = cfg_lead_delay;
    roll_phase = (delay_left != '0) ? PHASE_DELAY_CODE : PHASE_ROLL_CODE;
  endfunction

  // next roll state and result for one transfer
  function automatic srs_result_t predict_roll_step(input logic [OP_W-1:0] op,
                                                    input logic [DT_W-1:0] dt);
    logic [CANVAS_W-1:0] canvas;
    logic [OFFSET_W:0]   travel;
    logic [OFFSET_W:0]   sum;
    logic [DELAY_W-1:0]  dt_wide;
    logic                fin;
    logic                fire;
    fin     = 1'b0;
    fire    = 1'b0;
    dt_wide = DELAY_W'(dt);
    case (op)
      OP_TICK: begin
        canvas = (cfg_canvas == '0) ? CANVAS_W'(1) : cfg_canvas;
        travel = ((OFFSET_W + 1)'(canvas) + (OFFSET_W + 1)'(cfg_strip)) << TIME_FRAC;
        if (roll_phase == PHASE_DELAY_CODE) begin
          if (dt_wide >= delay_left) begin
            delay_left = '0;
            roll_phase = PHASE_ROLL_CODE;
          end else begin
            delay_left = delay_left - dt_wide;
          end
        end else if (roll_phase == PHASE_ROLL_CODE && !roll_paused) begin
          sum = (OFFSET_W + 1)'(roll_offset)
                + (OFFSET_W + 1)'(cfg_speed) * (OFFSET_W + 1)'(dt);
          if (sum < travel) begin
            roll_offset = sum[OFFSET_W-1:0];
          end else if (cfg_loop) begin
            sum = sum - travel;
            roll_offset = sum[OFFSET_W-1:0];
          end else begin
            roll_offset = travel[OFFSET_W-1:0];
            roll_phase  = PHASE_DONE_CODE;
            fin = 1'b1;
            if (cfg_action) begin
              action_pending = 1'b1;
              action_left    = cfg_action_delay;
            end
          end
        end
        // ending action countdown, any phase
        if (action_pending && !fin) begin
          if (dt_wide >= action_left) begin
            action_pending = 1'b0;
            action_left    = '0;
            fire = 1'b1;
          end else begin
            action_left = action_left - dt_wide;
          end
        end
        if (fin && cfg_action && cfg_action_delay == '0) begin
          action_pending = 1'b0;
          fire = 1'b1;
        end
      end
      OP_ARM:    arm_roll();
      OP_RESET:  clear_roll();
      OP_PAUSE:  roll_paused = 1'b1;
      OP_RESUME: roll_paused = 1'b0;
      OP_TOGGLE: roll_paused = ~roll_paused;
      OP_START: begin
        if (roll_phase == PHASE_IDLE_CODE || roll_phase == PHASE_DONE_CODE) arm_roll();
        else roll_paused = 1'b0;
      end
      default: ;
    endcase
    return '{roll_phase, roll_offset, fin, fire, roll_paused};
  endfunction

  // directed table rows
  function automatic plan_row_t plan_item(input logic [2:0] op,
                                          input logic [CFG_DATA_W-1:0] dt);
    return '{1'b0, op, dt, 1'b0, '0};
  endfunction

  function automatic plan_row_t plan_known(input logic [2:0] op,
                                           input logic [CFG_DATA_W-1:0] dt,
                                           input logic [PHASE_W-1:0] ph,
                                           input logic [OFFSET_W-1:0] offset,
                                           input logic fin, input logic fire,
                                           input logic paused);
    return '{1'b0, op, dt, 1'b1, '{ph, offset, fin, fire, paused}};
  endfunction

  function automatic plan_row_t plan_write(input logic [2:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
    return '{1'b1, idx, value, 1'b0, '0};
  endfunction

  // compare one field, print and count on a mismatch
  task automatic note_field(input string field, input logic [63:0] got,
                            input logic [63:0] want);
    if (got !== want) begin
      mismatch_count++;
      $display("mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
               result_count, field, got, want);
    end
  endtask

  // register write, only once every result is back
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_rolls.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_CANVAS:      cfg_canvas       = value[CANVAS_W-1:0];
      CFG_STRIP:       cfg_strip        = value[STRIP_W-1:0];
      CFG_SPEED:       cfg_speed        = value[SPEED_W-1:0];
      CFG_LEAD_DELAY:  cfg_lead_delay   = value[DELAY_W-1:0];
      CFG_LOOP_EN:     cfg_loop         = value[0];
      CFG_ACTION_EN:   cfg_action       = value[0];
      CFG_ACTION_DLY:  cfg_action_delay = value[DELAY_W-1:0];
      default: ;
    endcase
    write_count++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one input transfer, with an optional idle burst before it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DT_W-1:0] dt,
                           input logic typed, input srs_result_t want);
    srs_result_t predicted;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_elapsed_time <= dt;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = predict_roll_step(op, dt);
    expected_rolls.insert(expected_rolls.size(), typed ? want : predicted);
    item_count++;
    if (typed) typed_count++;
  endtask

  // result stall bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end
  end

  // result checking
  always @(posedge clk) begin : check_results
    srs_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      result_count++;
      if (expected_rolls.size() == 0) begin
        note_field("result with nothing expected", 64'd1, 64'd0);
      end else begin
        want = expected_rolls.pop_front();
        note_field("phase_now", 64'(out_phase_now), 64'(want.phase));
        note_field("scroll_offset", 64'(out_scroll_offset), 64'(want.offset));
        note_field("finished_pulse", 64'(out_finished_pulse), 64'(want.fin));
        note_field("action_fire", 64'(out_action_fire), 64'(want.fire));
        note_field("paused_now", 64'(out_paused_now), 64'(want.paused));
        if (want.fin) finish_count++;
        if (want.fire) fire_count++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_rolls.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned      p;
    int unsigned      n;
    int unsigned      r;
    logic [OP_W-1:0]  op;
    logic [DT_W-1:0]  dt;

    // register defaults and idle roll
    cfg_canvas       = CANVAS_RST;
    cfg_strip        = '0;
    cfg_speed        = SPEED_RST;
    cfg_lead_delay   = '0;
    cfg_loop         = 1'b0;
    cfg_action       = 1'b0;
    cfg_action_delay = '0;
    clear_roll();

    directed_plan = '{
      // reset state, unused code and pause handling while idle
      plan_known(OP_TICK,   26'h0,    PHASE_IDLE_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_known(OP_UNUSED, 26'hFFFF, PHASE_IDLE_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_known(OP_PAUSE,  26'h0,    PHASE_IDLE_CODE, 33'd0, 1'b0, 1'b0, 1'b1),
      plan_known(OP_TOGGLE, 26'h0,    PHASE_IDLE_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_known(OP_TOGGLE, 26'h0,    PHASE_IDLE_CODE, 33'd0, 1'b0, 1'b0, 1'b1),
      plan_known(OP_START,  26'h0,    PHASE_ROLL_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_item(OP_TICK, 26'hFFFF),
      plan_item(OP_PAUSE, 26'h0),
      plan_item(OP_TICK, 26'hFFFF),
      plan_item(OP_RESUME, 26'h0),
      plan_known(OP_RESET,  26'h0,    PHASE_IDLE_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      // one pixel canvas, top speed, short start delay, immediate action
      plan_write(CFG_CANVAS, 26'd1),
      plan_write(CFG_STRIP, 26'd0),
      plan_write(CFG_SPEED, 26'd2047),
      plan_write(CFG_ACTION_EN, 26'd1),
      plan_write(CFG_ACTION_DLY, 26'd0),
      plan_write(CFG_LEAD_DELAY, 26'd3),
      plan_write(CFG_UNUSED, 26'h3FFFFFF),
      plan_known(OP_ARM,    26'h0,    PHASE_DELAY_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_known(OP_TOGGLE, 26'h0,    PHASE_DELAY_CODE, 33'd0, 1'b0, 1'b0, 1'b1),
      plan_known(OP_START,  26'h0,    PHASE_DELAY_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_known(OP_TICK,   26'h2,    PHASE_DELAY_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      // leftover delay time is dropped on entry to rolling
      plan_known(OP_TICK,   26'hFFFF, PHASE_ROLL_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_known(OP_TICK,   26'hFFFF, PHASE_DONE_CODE, 33'h10000, 1'b1, 1'b1, 1'b0),
      plan_known(OP_TICK,   26'h0,    PHASE_DONE_CODE, 33'h10000, 1'b0, 1'b0, 1'b0),
      // delayed ending action, counted down after the finish
      plan_write(CFG_ACTION_DLY, 26'd5),
      plan_write(CFG_LEAD_DELAY, 26'd0),
      plan_known(OP_START,  26'h0,    PHASE_ROLL_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_known(OP_TICK,   26'hFFFF, PHASE_DONE_CODE, 33'h10000, 1'b1, 1'b0, 1'b0),
      plan_known(OP_TICK,   26'h4,    PHASE_DONE_CODE, 33'h10000, 1'b0, 1'b0, 1'b0),
      plan_known(OP_TICK,   26'h1,    PHASE_DONE_CODE, 33'h10000, 1'b0, 1'b1, 1'b0),
      // loop mode overshoot keeps the offset above the travel
      plan_write(CFG_LOOP_EN, 26'd1),
      plan_known(OP_ARM,    26'h0,    PHASE_ROLL_CODE, 33'd0, 1'b0, 1'b0, 1'b0),
      plan_item(OP_TICK, 26'hFFFF),
      plan_item(OP_TICK, 26'h0)
    };

    // hold reset, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    idle_pct = 25;
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write)
        write_cfg(directed_plan[i].code, directed_plan[i].arg);
      else
        send_item(directed_plan[i].code, directed_plan[i].arg[DT_W-1:0],
                  directed_plan[i].typed, directed_plan[i].want);
    end

    // random phases, each with its own register setting
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 1) begin
        // low extremes
        write_cfg(CFG_CANVAS, 26'd0);
        write_cfg(CFG_STRIP, 26'd0);
        write_cfg(CFG_SPEED, 26'd1);
        write_cfg(CFG_LEAD_DELAY, 26'd0);
        write_cfg(CFG_LOOP_EN, 26'd0);
        write_cfg(CFG_ACTION_EN, 26'd0);
        write_cfg(CFG_ACTION_DLY, 26'd0);
      end else if (p == 2) begin
        // high extremes
        write_cfg(CFG_CANVAS, 26'h3FFFFFF);
        write_cfg(CFG_STRIP, 26'h3FFFFFF);
        write_cfg(CFG_SPEED, 26'h3FFFFFF);
        write_cfg(CFG_LEAD_DELAY, 26'h3FFFFFF);
        write_cfg(CFG_LOOP_EN, 26'h3FFFFFF);
        write_cfg(CFG_ACTION_EN, 26'h3FFFFFF);
        write_cfg(CFG_ACTION_DLY, 26'h3FFFFFF);
      end else begin
        // mostly short travel so rolls finish or wrap within a phase
        write_cfg(CFG_CANVAS, {12'($urandom), ($urandom_range(0, 7) == 0) ?
                  14'($urandom_range(0, 16383)) : 14'($urandom_range(1, 200))});
        write_cfg(CFG_STRIP, {10'($urandom), ($urandom_range(0, 7) == 0) ?
                  16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 300))});
        write_cfg(CFG_SPEED, {15'($urandom), 11'($urandom_range(0, 2047))});
        write_cfg(CFG_LEAD_DELAY, ($urandom_range(0, 3) == 0) ?
                  26'd0 : 26'($urandom_range(1, 300000)));
        write_cfg(CFG_LOOP_EN, {25'($urandom), 1'($urandom_range(0, 1))});
        write_cfg(CFG_ACTION_EN, {25'($urandom), 1'($urandom_range(0, 2) != 0)});
        write_cfg(CFG_ACTION_DLY, ($urandom_range(0, 2) == 0) ?
                  26'd0 : 26'($urandom_range(1, 400000)));
      end

      // idle level for this phase, none at the end of the run
      if (p >= RANDOM_PHASES - QUIET_PHASES) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 10;
          2: idle_pct = 25;
          default: idle_pct = 50;
        endcase
      end

      // arm or start, then mostly ticks with commands mixed in
      send_item(($urandom_range(0, 1) != 0) ? OP_START : OP_ARM, 16'($urandom), 1'b0, '0);
      for (n = 1; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 64)      op = OP_TICK;
        else if (r < 70) op = OP_START;
        else if (r < 74) op = OP_ARM;
        else if (r < 76) op = OP_RESET;
        else if (r < 81) op = OP_PAUSE;
        else if (r < 89) op = OP_RESUME;
        else if (r < 95) op = OP_TOGGLE;
        else             op = OP_UNUSED;
        case ($urandom_range(0, 9))
          0:       dt = '0;
          1:       dt = '1;
          2:       dt = 16'($urandom_range(1, 16));
          default: dt = 16'($urandom);
        endcase
        send_item(op, dt, 1'b0, '0);
      end
    end

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (expected_rolls.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("covered %0d transfers in, %0d results checked (%0d with typed values)",
             item_count, result_count, typed_count);
    $display("%0d finishes, %0d action fires, %0d register writes over %0d random settings",
             finish_count, fire_count, write_count, RANDOM_PHASES);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
